[sv/acm_pkg.sv]
// Shared types and constants for the address resolution cache.
`timescale 1ns / 1ps

package acm_pkg;

  localparam int TableDepthDefault = 64;
  localparam logic [15:0] TimeoutReset = 16'd120;
  localparam logic [6:0] RemovedMax = 7'h7F;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_LOOKUP   = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_SWEEP    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [47:0] mac;
    logic [31:0] ip;
    logic        valid;
  } entry_t;

  localparam int EntryWidth = $bits(entry_t);

endpackage

[sv/acm_ram.sv]
// Single-port-write, single-port-read table memory with registered read data.
`timescale 1ns / 1ps

module acm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/acm_ctrl.sv]
// Request sequencer: table scans, updates, sweeps, clock counter and result register.
`timescale 1ns / 1ps

module acm_ctrl
  import acm_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [15:0]                    timeout,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [79:0]                    s_tdata,
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [55:0]                    m_tdata,
  output logic [1:0]                     m_tuser,
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output logic [EntryWidth-1:0]          ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  input  logic [EntryWidth-1:0]          ram_rdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(TABLE_DEPTH - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t        state;
  logic [AW-1:0] addr;
  logic [AW-1:0] eval_addr;
  logic [AW-1:0] hit_addr;
  logic [AW-1:0] free_addr;
  logic          issue;
  logic          rd_pend;
  logic          hit;
  logic          free_found;
  logic [31:0]   now_sec;
  req_t          cur_req;
  logic [31:0]   req_ip;
  logic [47:0]   req_mac;
  status_t       res_status;
  logic [47:0]   res_mac;
  logic [6:0]    res_removed;
  status_t       out_status;
  logic [47:0]   out_mac;
  logic [6:0]    out_removed;

  entry_t        rd_entry;
  entry_t        wr_entry;
  logic [31:0]   age;
  logic          match;
  logic          expire;
  logic          last_eval;

  assign rd_entry  = entry_t'(ram_rdata);
  assign age       = now_sec - rd_entry.stamp;
  assign match     = rd_pend && rd_entry.valid && (rd_entry.ip == req_ip);
  assign expire    = rd_pend && rd_entry.valid && (age > {16'd0, timeout});
  assign last_eval = (eval_addr == LastAddr);

  assign s_tready  = (state == ST_IDLE);
  assign m_tdata   = {1'b0, out_removed, out_mac};
  assign m_tuser   = out_status;
  assign ram_re    = (state == ST_SCAN) && issue;
  assign ram_raddr = addr;
  assign ram_wdata = wr_entry;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = eval_addr;
    wr_entry  = rd_entry;
    wr_entry.valid = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr;
        wr_entry  = '0;
      end
      ST_SCAN: begin
        ram_we = (cur_req == REQ_SWEEP) && expire;
      end
      ST_WRITE: begin
        ram_we    = hit || free_found;
        ram_waddr = hit ? hit_addr : free_addr;
        wr_entry  = '{stamp: now_sec, mac: req_mac, ip: req_ip, valid: 1'b1};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      addr       <= '0;
      issue      <= 1'b0;
      rd_pend    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      now_sec    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (addr == LastAddr) begin
            addr  <= '0;
            state <= ST_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_req     <= req_t'(s_tuser);
            req_ip      <= s_tdata[31:0];
            req_mac     <= s_tdata[79:32];
            res_status  <= STAT_OK;
            res_mac     <= '0;
            res_removed <= '0;
            hit         <= 1'b0;
            free_found  <= 1'b0;
            addr        <= '0;
            issue       <= 1'b1;
            rd_pend     <= 1'b0;
            if (req_t'(s_tuser) == REQ_TICK) begin
              now_sec <= now_sec + 32'd1;
              state   <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_pend   <= issue;
          eval_addr <= addr;
          if (issue) begin
            if (addr == LastAddr) begin
              issue <= 1'b0;
            end else begin
              addr <= addr + 1'b1;
            end
          end
          if (rd_pend) begin
            if (match) begin
              hit      <= 1'b1;
              hit_addr <= eval_addr;
              if (cur_req == REQ_LOOKUP) begin
                res_mac <= rd_entry.mac;
              end
            end
            if (!free_found && !rd_entry.valid) begin
              free_found <= 1'b1;
              free_addr  <= eval_addr;
            end
            if (cur_req == REQ_SWEEP && expire && res_removed != RemovedMax) begin
              res_removed <= res_removed + 7'd1;
            end
            if ((match && cur_req != REQ_SWEEP) || last_eval) begin
              case (cur_req)
                REQ_REGISTER: state <= ST_WRITE;
                REQ_LOOKUP: begin
                  if (!match) begin
                    res_status <= STAT_NOT_FOUND;
                  end
                  state <= ST_DONE;
                end
                default: state <= ST_DONE;
              endcase
            end
          end
        end
        ST_WRITE: begin
          if (!hit && !free_found) begin
            res_status <= STAT_FULL;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            out_status  <= res_status;
            out_mac     <= res_mac;
            out_removed <= res_removed;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("table written while idle");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != ST_IDLE))
    else $error("request accepted without leaving idle");

  a_removed_sweep_only: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && cur_req != REQ_SWEEP) |-> (res_removed == 7'd0))
    else $error("removal count set outside a sweep");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == STAT_NOT_FOUND) |-> (out_mac == 48'd0))
    else $error("failed lookup returned a MAC");

endmodule

[sv/arp_cache_with_aging.sv]
// Top level of the address resolution cache with entry aging.
`timescale 1ns / 1ps

// Requests enter on the s_axis channel: tuser carries the request kind (register, lookup,
// tick, sweep) and tdata the IPv4 and MAC addresses. Each request yields exactly one
// result on the m_axis channel: tuser carries the status, tdata the MAC found by a lookup
// and the number of entries removed by a sweep. The timeout is written over the cfg
// channel, which is always ready.
// A tick passes from idle straight to the done state, which loads the result register.
// A lookup scans the table one entry per cycle through the memory read port and stops
// at the first match; a sweep always scans the whole table, and a register scans to a
// match or the last entry, then writes if it has a slot. One request is in work at a time.
// After reset a clearing pass empties every table entry; no request is accepted during it,
// and the timeout returns to 120 with the clock counter at zero.
// A result waits in the output register while the receiver stalls; the next request is
// accepted and scanned meanwhile, and holds its own result until the register is free.
module arp_cache_with_aging
  import acm_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // ip_addr[31:0], mac_addr[79:32]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // mac_out[47:0], removed_count[54:48], zero[55]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [15:0]         timeout;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EntryWidth-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [EntryWidth-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TimeoutReset;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= cfg_data;
    end
  end

  acm_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .timeout   (timeout),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata),
    .m_tuser   (m_axis_tuser),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  acm_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(EntryWidth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the address resolution cache with entry aging.
`timescale 1ns / 1ps

module tb_top;
  import acm_pkg::*;

  localparam int TableDepth = TableDepthDefault;
  localparam int NumDrill = 23;
  localparam int NumPhases = 8;
  localparam int ItemsPerPhase = 210;
  localparam int PoolMax = 100;
  localparam int FillBurst = 70;
  localparam int LongHoldCycles = 600;
  localparam int CycleLimit = 1_000_000;

  typedef struct packed {
    status_t     status;
    logic [47:0] mac;
    logic [6:0]  removed;
  } arp_resp_t;

  typedef struct packed {
    logic        set_timeout;
    logic [15:0] timeout;
    req_t        kind;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        typed;
    status_t     status;
    logic [47:0] mac_out;
    logic [6:0]  removed;
  } drill_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // ip_addr[31:0], mac_addr[79:32]
  logic [1:0]  s_axis_tuser = '0;  // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // mac_out[47:0], removed_count[54:48], zero[55]
  logic [1:0]  m_axis_tuser;       // status[1:0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  logic        cache_valid [TableDepth];
  logic [31:0] cache_ip [TableDepth];
  logic [47:0] cache_mac [TableDepth];
  logic [31:0] cache_stamp [TableDepth];
  logic [31:0] cache_now = '0;
  logic [15:0] cache_timeout = TimeoutReset;

  arp_resp_t   pending_results [$];
  arp_resp_t   want;
  int          fault_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycles;

  drill_row_t drill_rows [NumDrill] = '{
    '{1'b0, 16'd0, REQ_LOOKUP, 32'h0, 48'h0, 1'b1, STAT_NOT_FOUND, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_SWEEP, 32'h0, 48'h0, 1'b1, STAT_OK, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_TICK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, STAT_OK, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_REGISTER, 32'h0, 48'h0, 1'b1, STAT_OK, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_LOOKUP, 32'h0, 48'h0, 1'b1, STAT_OK, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_REGISTER, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, STAT_OK, 48'h0,
      7'd0},
    '{1'b0, 16'd0, REQ_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b1, STAT_OK, 48'hFFFF_FFFF_FFFF,
      7'd0},
    '{1'b0, 16'd0, REQ_REGISTER, 32'h0, 48'hA5A5_A5A5_A5A5, 1'b1, STAT_OK, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_LOOKUP, 32'h0, 48'h0, 1'b1, STAT_OK, 48'hA5A5_A5A5_A5A5, 7'd0},
    '{1'b0, 16'd0, REQ_LOOKUP, 32'h0A00_0001, 48'h0, 1'b1, STAT_NOT_FOUND, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_REGISTER, 32'hC0A8_0001, 48'h0123_4567_89AB, 1'b0, STAT_OK, 48'h0,
      7'd0},
    '{1'b0, 16'd0, REQ_TICK, 32'h0, 48'h0, 1'b0, STAT_OK, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_SWEEP, 32'h0, 48'h0, 1'b0, STAT_OK, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_LOOKUP, 32'hC0A8_0001, 48'h0, 1'b0, STAT_OK, 48'h0, 7'd0},
    '{1'b1, 16'd0, REQ_TICK, 32'h0, 48'h0, 1'b0, STAT_OK, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_REGISTER, 32'h5A5A_5A5A, 48'h5A5A_5A5A_5A5A, 1'b0, STAT_OK, 48'h0,
      7'd0},
    '{1'b0, 16'd0, REQ_SWEEP, 32'h0, 48'h0, 1'b0, STAT_OK, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_LOOKUP, 32'h5A5A_5A5A, 48'h0, 1'b0, STAT_OK, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_LOOKUP, 32'h0, 48'h0, 1'b0, STAT_OK, 48'h0, 7'd0},
    '{1'b1, 16'hFFFF, REQ_TICK, 32'h0, 48'h0, 1'b0, STAT_OK, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_SWEEP, 32'h0, 48'h0, 1'b0, STAT_OK, 48'h0, 7'd0},
    '{1'b1, 16'd120, REQ_REGISTER, 32'h5A5A_5A5A, 48'h0, 1'b0, STAT_OK, 48'h0, 7'd0},
    '{1'b0, 16'd0, REQ_LOOKUP, 32'h5A5A_5A5A, 48'h0, 1'b0, STAT_OK, 48'h0, 7'd0}
  };

  arp_cache_with_aging #(
    .TABLE_DEPTH(TableDepth)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int find_entry(logic [31:0] ip);
    int hit;
    hit = -1;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (cache_valid[i] && cache_ip[i] == ip) hit = i;
    end
    return hit;
  endfunction

  function automatic arp_resp_t resolve_request(req_t kind, logic [31:0] ip,
                                                logic [47:0] mac);
    arp_resp_t   r;
    int          slot;
    logic [31:0] age;
    r = '{status: STAT_OK, mac: 48'h0, removed: 7'd0};
    case (kind)
      REQ_REGISTER: begin
        slot = find_entry(ip);
        for (int i = TableDepth - 1; i >= 0; i--) begin
          if (find_entry(ip) < 0 && !cache_valid[i]) slot = i;
        end
        if (slot < 0) begin
          r.status = STAT_FULL;
        end else begin
          cache_valid[slot] = 1'b1;
          cache_ip[slot] = ip;
          cache_mac[slot] = mac;
          cache_stamp[slot] = cache_now;
        end
      end
      REQ_LOOKUP: begin
        slot = find_entry(ip);
        if (slot < 0) r.status = STAT_NOT_FOUND;
        else r.mac = cache_mac[slot];
      end
      REQ_TICK: begin
        cache_now = cache_now + 32'd1;
      end
      default: begin
        for (int i = 0; i < TableDepth; i++) begin
          age = cache_now - cache_stamp[i];
          if (cache_valid[i] && age > {16'd0, cache_timeout}) begin
            cache_valid[i] = 1'b0;
            if (r.removed != RemovedMax) r.removed = r.removed + 7'd1;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  task automatic send_request(req_t kind, logic [31:0] ip, logic [47:0] mac, logic typed,
                              arp_resp_t typed_resp);
    arp_resp_t guess;
    int        gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {mac, ip};
    do @(posedge clk); while (!s_axis_tready);
    guess = resolve_request(kind, ip, mac);
    pending_results.push_back(typed ? typed_resp : guess);
  endtask

  task automatic write_timeout(logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cache_timeout = value;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= LongHoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", m_axis_tuser);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
          fault_count++;
        end
        if (m_axis_tdata[47:0] !== want.mac) begin
          $error("mac_out: expected %h, actual %h", want.mac, m_axis_tdata[47:0]);
          fault_count++;
        end
        if (m_axis_tdata[54:48] !== want.removed) begin
          $error("removed_count: expected %0d, actual %0d", want.removed,
                 m_axis_tdata[54:48]);
          fault_count++;
        end
      end
    end
  end

  initial begin
    for (cycles = 0; cycles < CycleLimit; cycles++) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin : main_seq
    logic [31:0] ip_pool [PoolMax];
    logic [31:0] ip;
    req_t        kind;
    arp_resp_t   typed_resp;
    int          phase;
    int          sent;
    int          pick;
    int          base;
    int          pool_size;
    for (int i = 0; i < TableDepth; i++) begin
      cache_valid[i] = 1'b0;
      cache_ip[i] = '0;
      cache_mac[i] = '0;
      cache_stamp[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NumDrill; r++) begin
      if (drill_rows[r].set_timeout) write_timeout(drill_rows[r].timeout);
      typed_resp = '{status: drill_rows[r].status, mac: drill_rows[r].mac_out,
                     removed: drill_rows[r].removed};
      send_request(drill_rows[r].kind, drill_rows[r].ip, drill_rows[r].mac,
                   drill_rows[r].typed, typed_resp);
    end

    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: write_timeout(16'd0);
        1: write_timeout(16'd3);
        2: write_timeout(16'hFFFF);
        3: write_timeout(16'd1);
        4: write_timeout(16'($urandom_range(65535)));
        5: write_timeout(16'd10);
        6: write_timeout(16'd120);
        default: write_timeout(16'd2);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 49; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 49; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (phase % 4 == 0) hold_token++;
      pool_size = phase[0] ? PoolMax : $urandom_range(40, 8);
      for (int k = 0; k < PoolMax; k++) ip_pool[k] = $urandom;
      sent = 0;
      while (sent < ItemsPerPhase) begin
        pick = $urandom_range(99);
        if (pool_size == PoolMax && pick < 3) begin
          // A run of distinct addresses fills the table and then meets a full table.
          base = $urandom_range(PoolMax - 1);
          for (int k = 0; k < FillBurst; k++) begin
            send_request(REQ_REGISTER, ip_pool[(base + k) % PoolMax], rand_mac(), 1'b0, '0);
          end
          sent += FillBurst;
        end else begin
          if (pick < 35) kind = REQ_REGISTER;
          else if (pick < 70) kind = REQ_LOOKUP;
          else if (pick < 88) kind = REQ_TICK;
          else kind = REQ_SWEEP;
          ip = ($urandom_range(9) == 0) ? $urandom : ip_pool[$urandom_range(pool_size - 1)];
          send_request(kind, ip, rand_mac(), 1'b0, '0);
          sent++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 * TableDepth) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/acm_pkg.sv
sv/acm_ram.sv
sv/acm_ctrl.sv
sv/arp_cache_with_aging.sv
verif/tb_top.sv
